// ===== sv/gmbfs_pkg.sv =====
// Shared types and constants of the grid maze shortest-path search block.
`timescale 1ns / 1ps
`default_nettype none

package gmbfs_pkg;

    localparam int CELL_W     = 8;   // cell coordinate width
    localparam int ROOM_W     = 7;   // room coordinate width
    localparam int DIM_W      = 7;   // room count register width
    localparam int DEP_W      = 14;  // search depth width, holds up to 127 * 127 rooms
    localparam int DIST_W     = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [0:0] {
        CMD_LOAD   = 1'b0,
        CMD_SEARCH = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROOMS_TALL = 3'd0,
        CFG_ROOMS_WIDE = 3'd1,
        CFG_START_ROW  = 3'd2,
        CFG_START_COL  = 3'd3,
        CFG_END_ROW    = 3'd4,
        CFG_END_COL    = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIR_EAST  = 2'd0,
        DIR_SOUTH = 2'd1,
        DIR_WEST  = 2'd2,
        DIR_NORTH = 2'd3
    } t_dir;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_CLEAR = 3'd1,
        ST_START = 3'd2,
        ST_LOOP  = 3'd3,
        ST_WALL  = 3'd4,
        ST_ROOM  = 3'd5,
        ST_CHECK = 3'd6,
        ST_OUT   = 3'd7
    } t_state;

    typedef struct packed {
        logic [ROOM_W-1:0] row;
        logic [ROOM_W-1:0] col;
        logic [DEP_W-1:0]  dep;
    } t_qent;

endpackage

`default_nettype wire

// ===== sv/gmbfs_if.sv =====
// Handshake channel interfaces of the grid maze shortest-path search block.
`timescale 1ns / 1ps
`default_nettype none

interface gmbfs_in_if;
    logic                            valid;
    logic                            ready;
    logic                            command;
    logic [gmbfs_pkg::CELL_W-1:0]    cell_row;
    logic [gmbfs_pkg::CELL_W-1:0]    cell_col;
    logic                            passable;

    modport source (output valid, command, cell_row, cell_col, passable, input ready);
    modport sink   (input valid, command, cell_row, cell_col, passable, output ready);
endinterface

interface gmbfs_out_if;
    logic                            valid;
    logic                            ready;
    logic [gmbfs_pkg::DIST_W-1:0]    distance;
    logic                            reached;

    modport source (output valid, distance, reached, input ready);
    modport sink   (input valid, distance, reached, output ready);
endinterface

interface gmbfs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [gmbfs_pkg::CFG_IDX_W-1:0]   index;
    logic [gmbfs_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/gmbfs_cell_mem.sv =====
// Cell passability store with its row-major address unit and registered read.
`timescale 1ns / 1ps
`default_nettype none

module gmbfs_cell_mem #(
    parameter int MAX_ROOMS_TALL = 64,
    parameter int MAX_ROOMS_WIDE = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [gmbfs_pkg::CELL_W-1:0] i_row,
    input  wire logic [gmbfs_pkg::CELL_W-1:0] i_col,
    input  wire logic                         i_wdata,
    output logic                              o_rdata
);

    localparam int CELL_ROWS = 2 * MAX_ROOMS_TALL + 1;
    localparam int CELL_COLS = 2 * MAX_ROOMS_WIDE + 1;
    localparam int DEPTH     = CELL_ROWS * CELL_COLS;
    localparam int AW        = $clog2(DEPTH);

    logic          r_mem [DEPTH];
    logic [AW-1:0] addr;

    // One address unit serves loads and both reads of every search step.
    assign addr = AW'(32'(i_row) * CELL_COLS + 32'(i_col));

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[addr] <= i_wdata;
        end
        o_rdata <= r_mem[addr];
    end

endmodule

`default_nettype wire

// ===== sv/grid_maze_bfs_shortest_path.sv =====
// Top level of the grid maze breadth-first shortest-path search block.
//
// Usage: the input channel carries load beats (command 0), each writing one
// cell's passable bit, and search beats (command 1). Loads are taken one per
// cycle while the block is idle; a load outside the store is dropped. A search
// beat produces exactly one result beat with the fewest room moves and a
// reached flag; loads produce none. Configuration writes (maze size, start and
// end cells) go through the separate configuration channel, which is always
// ready; the user must make them only while the block is idle, as the block
// itself does not enforce this. A search sweeps the visited store clear
// (MAX_ROOMS_TALL * MAX_ROOMS_WIDE rooms, 4096 at the default sizes),
// seeds the queue, then for each dequeued room tries the four directions in
// turn, finds the queue empty when the end is not reached, and hands over the
// result. For a neighbour inside the maze, the single-port cell store is read
// once for the wall and, if the wall is open, once for the target room.
// The input is not ready during a search. The result sits in an output
// register; when the receiver stalls, the finished search waits until that
// register is free. Reset is synchronous: it returns the block to idle, drops
// any pending result and sets every configuration register to 1. Maze
// contents are not cleared by reset.
`timescale 1ns / 1ps
`default_nettype none

module grid_maze_bfs_shortest_path #(
    parameter int MAX_ROOMS_TALL = 64,
    parameter int MAX_ROOMS_WIDE = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    gmbfs_in_if.sink      i_in,
    gmbfs_out_if.source   o_out,
    gmbfs_cfg_if.sink     i_cfg
);

    localparam int CELL_ROWS  = 2 * MAX_ROOMS_TALL + 1;
    localparam int CELL_COLS  = 2 * MAX_ROOMS_WIDE + 1;
    localparam int ROOM_COUNT = MAX_ROOMS_TALL * MAX_ROOMS_WIDE;
    localparam int VAW        = (ROOM_COUNT > 1) ? $clog2(ROOM_COUNT) : 1;
    localparam int QPW        = $clog2(ROOM_COUNT + 1);

    localparam int CW  = gmbfs_pkg::CELL_W;
    localparam int RW  = gmbfs_pkg::ROOM_W;
    localparam int DW  = gmbfs_pkg::DIM_W;
    localparam int DPW = gmbfs_pkg::DEP_W;
    localparam int SW  = gmbfs_pkg::DIST_W;

    // Configuration registers
    logic [DW-1:0] r_rooms_tall;
    logic [DW-1:0] r_rooms_wide;
    logic [CW-1:0] r_start_row;
    logic [CW-1:0] r_start_col;
    logic [CW-1:0] r_end_row;
    logic [CW-1:0] r_end_col;

    // Sequencer state
    gmbfs_pkg::t_state r_state, n_state;
    gmbfs_pkg::t_dir   r_dir, n_dir;
    logic [VAW-1:0]    r_clr, n_clr;
    logic [QPW-1:0]    r_head, n_head;
    logic [QPW-1:0]    r_tail, n_tail;
    logic [SW-1:0]     r_res_dist, n_res_dist;
    logic              r_res_reached, n_res_reached;

    // Output register
    logic          r_out_valid;
    logic [SW-1:0] r_out_dist;
    logic          r_out_reached;

    // Stores
    logic              r_visited [ROOM_COUNT];
    logic              r_vis_rd;
    gmbfs_pkg::t_qent  r_queue [ROOM_COUNT];
    gmbfs_pkg::t_qent  r_q_rd;
    logic              r_cell_rd;

    logic              load_acc;
    logic              search_acc;
    logic              load_in_range;
    logic [DW-1:0]     tall_eff;
    logic [DW-1:0]     wide_eff;
    logic [RW-1:0]     start_r;
    logic [RW-1:0]     start_c;
    logic              start_ok;
    logic              start_is_end;

    logic [RW-1:0]     nb_r;
    logic [RW-1:0]     nb_c;
    logic              nb_in;
    logic [CW-1:0]     wall_r;
    logic [CW-1:0]     wall_c;
    logic              nb_is_end;
    logic              new_room;
    logic              found;
    logic              last_dir;
    logic              advance;
    logic [DPW-1:0]    dep_next;
    logic [SW-1:0]     dist_sat;

    logic [RW-1:0]     vis_r;
    logic [RW-1:0]     vis_c;
    logic [VAW-1:0]    vis_idx;
    logic              vis_we;
    logic              vis_wdata;
    logic [VAW-1:0]    vis_waddr;

    logic              q_we;
    logic [VAW-1:0]    q_waddr;
    gmbfs_pkg::t_qent  q_wdata;

    logic              cm_we;
    logic [CW-1:0]     cm_row;
    logic [CW-1:0]     cm_col;
    logic              out_load;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == gmbfs_pkg::ST_IDLE);

    assign o_out.valid    = r_out_valid;
    assign o_out.distance = r_out_dist;
    assign o_out.reached  = r_out_reached;

    assign load_acc   = i_in.valid && i_in.ready && (i_in.command == gmbfs_pkg::CMD_LOAD);
    assign search_acc = i_in.valid && i_in.ready && (i_in.command == gmbfs_pkg::CMD_SEARCH);
    assign load_in_range = (32'(i_in.cell_row) < CELL_ROWS) && (32'(i_in.cell_col) < CELL_COLS);

    // Room counts above the store size behave as the store size.
    assign tall_eff = (32'(r_rooms_tall) > MAX_ROOMS_TALL) ? DW'(MAX_ROOMS_TALL) : r_rooms_tall;
    assign wide_eff = (32'(r_rooms_wide) > MAX_ROOMS_WIDE) ? DW'(MAX_ROOMS_WIDE) : r_rooms_wide;

    assign start_r      = r_start_row[CW-1:1];
    assign start_c      = r_start_col[CW-1:1];
    assign start_ok     = r_start_row[0] && r_start_col[0] && (start_r < tall_eff)
                          && (start_c < wide_eff);
    assign start_is_end = (r_start_row == r_end_row) && (r_start_col == r_end_col);

    // Neighbour of the room at the queue head in the current direction, and
    // the wall cell that lies between the two.
    always_comb begin
        nb_r   = r_q_rd.row;
        nb_c   = r_q_rd.col;
        nb_in  = 1'b0;
        wall_r = {r_q_rd.row, 1'b1};
        wall_c = {r_q_rd.col, 1'b1};
        case (r_dir)
            gmbfs_pkg::DIR_EAST: begin
                nb_c   = r_q_rd.col + RW'(1);
                nb_in  = (nb_c < wide_eff);
                wall_c = {r_q_rd.col, 1'b0} + CW'(2);
            end
            gmbfs_pkg::DIR_SOUTH: begin
                nb_r   = r_q_rd.row + RW'(1);
                nb_in  = (nb_r < tall_eff);
                wall_r = {r_q_rd.row, 1'b0} + CW'(2);
            end
            gmbfs_pkg::DIR_WEST: begin
                nb_c   = r_q_rd.col - RW'(1);
                nb_in  = (r_q_rd.col != '0);
                wall_c = {r_q_rd.col, 1'b0};
            end
            gmbfs_pkg::DIR_NORTH: begin
                nb_r   = r_q_rd.row - RW'(1);
                nb_in  = (r_q_rd.row != '0);
                wall_r = {r_q_rd.row, 1'b0};
            end
            default: begin
                nb_in = 1'b0;
            end
        endcase
    end

    assign nb_is_end = ({nb_r, 1'b1} == r_end_row) && ({nb_c, 1'b1} == r_end_col);
    assign new_room  = r_cell_rd && !r_vis_rd;
    assign found     = new_room && nb_is_end;
    assign last_dir  = (r_dir == gmbfs_pkg::DIR_NORTH);
    assign advance   = ((r_state == gmbfs_pkg::ST_WALL)  && !nb_in)
                    || ((r_state == gmbfs_pkg::ST_ROOM)  && !r_cell_rd)
                    || ((r_state == gmbfs_pkg::ST_CHECK) && !found);

    assign dep_next = r_q_rd.dep + DPW'(1);
    assign dist_sat = (dep_next > DPW'(gmbfs_pkg::DIST_MAX)) ? gmbfs_pkg::DIST_MAX
                                                              : dep_next[SW-1:0];

    assign vis_r   = (r_state == gmbfs_pkg::ST_START) ? start_r : nb_r;
    assign vis_c   = (r_state == gmbfs_pkg::ST_START) ? start_c : nb_c;
    assign vis_idx = VAW'(32'(vis_r) * MAX_ROOMS_WIDE + 32'(vis_c));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gmbfs_pkg::ST_IDLE: begin
                if (search_acc) begin
                    n_state = gmbfs_pkg::ST_CLEAR;
                end
            end
            gmbfs_pkg::ST_CLEAR: begin
                if (r_clr == VAW'(ROOM_COUNT - 1)) begin
                    n_state = gmbfs_pkg::ST_START;
                end
            end
            gmbfs_pkg::ST_START: begin
                if (!start_ok || start_is_end) begin
                    n_state = gmbfs_pkg::ST_OUT;
                end else begin
                    n_state = gmbfs_pkg::ST_LOOP;
                end
            end
            gmbfs_pkg::ST_LOOP: begin
                if (r_head == r_tail) begin
                    n_state = gmbfs_pkg::ST_OUT;
                end else begin
                    n_state = gmbfs_pkg::ST_WALL;
                end
            end
            gmbfs_pkg::ST_WALL: begin
                if (!nb_in) begin
                    n_state = last_dir ? gmbfs_pkg::ST_LOOP : gmbfs_pkg::ST_WALL;
                end else begin
                    n_state = gmbfs_pkg::ST_ROOM;
                end
            end
            gmbfs_pkg::ST_ROOM: begin
                if (!r_cell_rd) begin
                    n_state = last_dir ? gmbfs_pkg::ST_LOOP : gmbfs_pkg::ST_WALL;
                end else begin
                    n_state = gmbfs_pkg::ST_CHECK;
                end
            end
            gmbfs_pkg::ST_CHECK: begin
                if (found) begin
                    n_state = gmbfs_pkg::ST_OUT;
                end else begin
                    n_state = last_dir ? gmbfs_pkg::ST_LOOP : gmbfs_pkg::ST_WALL;
                end
            end
            gmbfs_pkg::ST_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = gmbfs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gmbfs_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath controls
    always_comb begin
        n_clr         = r_clr;
        n_head        = r_head;
        n_tail        = r_tail;
        n_dir         = r_dir;
        n_res_dist    = r_res_dist;
        n_res_reached = r_res_reached;
        vis_we        = 1'b0;
        vis_wdata     = 1'b0;
        vis_waddr     = vis_idx;
        q_we          = 1'b0;
        q_waddr       = r_tail[VAW-1:0];
        q_wdata       = '{row: nb_r, col: nb_c, dep: dep_next};
        cm_we         = 1'b0;
        cm_row        = i_in.cell_row;
        cm_col        = i_in.cell_col;
        out_load      = 1'b0;
        if (advance) begin
            n_dir = gmbfs_pkg::t_dir'(r_dir + 2'd1);
        end
        case (r_state)
            gmbfs_pkg::ST_IDLE: begin
                cm_we = load_acc && load_in_range;
                n_clr = '0;
            end
            gmbfs_pkg::ST_CLEAR: begin
                vis_we    = 1'b1;
                vis_waddr = r_clr;
                n_clr     = r_clr + VAW'(1);
            end
            gmbfs_pkg::ST_START: begin
                n_res_dist    = '0;
                n_res_reached = start_ok && start_is_end;
                n_head        = '0;
                n_tail        = QPW'(1);
                vis_we        = start_ok && !start_is_end;
                vis_wdata     = 1'b1;
                q_we          = start_ok && !start_is_end;
                q_waddr       = '0;
                q_wdata       = '{row: start_r, col: start_c, dep: '0};
            end
            gmbfs_pkg::ST_LOOP: begin
                n_dir = gmbfs_pkg::DIR_EAST;
                if (r_head == r_tail) begin
                    n_res_dist    = '0;
                    n_res_reached = 1'b0;
                end else begin
                    n_head = r_head + QPW'(1);
                end
            end
            gmbfs_pkg::ST_WALL: begin
                cm_row = wall_r;
                cm_col = wall_c;
            end
            gmbfs_pkg::ST_ROOM: begin
                cm_row = {nb_r, 1'b1};
                cm_col = {nb_c, 1'b1};
            end
            gmbfs_pkg::ST_CHECK: begin
                if (found) begin
                    n_res_dist    = dist_sat;
                    n_res_reached = 1'b1;
                end else if (new_room) begin
                    vis_we    = 1'b1;
                    vis_wdata = 1'b1;
                    if (r_tail < QPW'(ROOM_COUNT)) begin
                        q_we   = 1'b1;
                        n_tail = r_tail + QPW'(1);
                    end
                end
            end
            gmbfs_pkg::ST_OUT: begin
                out_load = !r_out_valid || o_out.ready;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= gmbfs_pkg::ST_IDLE;
            r_dir         <= gmbfs_pkg::DIR_EAST;
            r_clr         <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dir   <= n_dir;
            r_clr   <= n_clr;
            r_head  <= n_head;
            r_tail  <= n_tail;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_dist    <= n_res_dist;
        r_res_reached <= n_res_reached;
        if (out_load) begin
            r_out_dist    <= r_res_dist;
            r_out_reached <= r_res_reached;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rooms_tall <= DW'(1);
            r_rooms_wide <= DW'(1);
            r_start_row  <= CW'(1);
            r_start_col  <= CW'(1);
            r_end_row    <= CW'(1);
            r_end_col    <= CW'(1);
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (gmbfs_pkg::t_cfg_idx'(i_cfg.index))
                gmbfs_pkg::CFG_ROOMS_TALL: r_rooms_tall <= i_cfg.data[DW-1:0];
                gmbfs_pkg::CFG_ROOMS_WIDE: r_rooms_wide <= i_cfg.data[DW-1:0];
                gmbfs_pkg::CFG_START_ROW:  r_start_row  <= i_cfg.data;
                gmbfs_pkg::CFG_START_COL:  r_start_col  <= i_cfg.data;
                gmbfs_pkg::CFG_END_ROW:    r_end_row    <= i_cfg.data;
                gmbfs_pkg::CFG_END_COL:    r_end_col    <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Visited store: one bit per room, swept clear before every search.
    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            r_visited[vis_waddr] <= vis_wdata;
        end
        r_vis_rd <= r_visited[vis_idx];
    end

    // Frontier queue: rooms in visiting order with their depth.
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_queue[q_waddr] <= q_wdata;
        end
        if (r_state == gmbfs_pkg::ST_LOOP) begin
            r_q_rd <= r_queue[r_head[VAW-1:0]];
        end
    end

    gmbfs_cell_mem #(
        .MAX_ROOMS_TALL (MAX_ROOMS_TALL),
        .MAX_ROOMS_WIDE (MAX_ROOMS_WIDE)
    ) u_cell_mem (
        .i_clk   (i_clk),
        .i_we    (cm_we),
        .i_row   (cm_row),
        .i_col   (cm_col),
        .i_wdata (i_in.passable),
        .o_rdata (r_cell_rd)
    );

endmodule

`default_nettype wire

// ===== sv/gmbfs_checker.sv =====
// Port-level assertions for the grid maze shortest-path search block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module gmbfs_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic                          i_in_command,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [gmbfs_pkg::DIST_W-1:0]  i_out_distance,
    input wire logic                          i_out_reached
);

    // A stalled result beat keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_distance)
                                        && $stable(i_out_reached))
        else $error("result beat changed while stalled");

    // An unreached end always reports a distance of zero.
    a_unreached_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_reached |-> i_out_distance == '0)
        else $error("unreached result with non-zero distance");

    // A search beat makes the block busy on the following cycle.
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_command == gmbfs_pkg::CMD_SEARCH) |=> !i_in_ready)
        else $error("input ready straight after a search beat");

    // Reset leaves the block idle with no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("block not idle after reset");

endmodule

bind grid_maze_bfs_shortest_path gmbfs_checker u_gmbfs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_command   (i_in.command),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_distance (o_out.distance),
    .i_out_reached  (o_out.reached)
);

`default_nettype wire

// ===== tb/sv/grid_maze_bfs_shortest_path_tb.sv =====
// Testbench of the grid maze shortest-path block: random mazes and searches against a software BFS.
`timescale 1ns / 1ps

module grid_maze_bfs_shortest_path_tb;

    localparam int CELL_W     = gmbfs_pkg::CELL_W;
    localparam int DIM_W      = gmbfs_pkg::DIM_W;
    localparam int DIST_W     = gmbfs_pkg::DIST_W;
    localparam int CFG_DATA_W = gmbfs_pkg::CFG_DATA_W;
    localparam logic [DIST_W-1:0] DIST_MAX = gmbfs_pkg::DIST_MAX;

    localparam int MAX_T         = 64;
    localparam int MAX_W         = 64;
    localparam int CELL_ROWS     = 2 * MAX_T + 1;
    localparam int CELL_COLS     = 2 * MAX_W + 1;
    localparam int ROOM_COUNT    = MAX_T * MAX_W;
    localparam int ITEM_GOAL     = 1750;
    localparam int PATH_GOAL     = 48;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 12000;
    localparam int STALL_LIMIT   = 200000;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              reached;
    } t_path_result;

    // Keeps a copy of the maze and the registers, works out each search and
    // checks the result beats in order.
    class maze_path_board;
        bit [CELL_ROWS*CELL_COLS-1:0] open_cells;
        bit [ROOM_COUNT-1:0]          seen_rooms;
        bit [DIM_W-1:0]               rooms_tall;
        bit [DIM_W-1:0]               rooms_wide;
        bit [CELL_W-1:0]              start_row;
        bit [CELL_W-1:0]              start_col;
        bit [CELL_W-1:0]              end_row;
        bit [CELL_W-1:0]              end_col;
        t_path_result                 awaited_paths[$];
        int                           paths_checked;
        int                           mismatches;

        function new();
            open_cells    = '0;
            seen_rooms    = '0;
            rooms_tall    = DIM_W'(1);
            rooms_wide    = DIM_W'(1);
            start_row     = CELL_W'(1);
            start_col     = CELL_W'(1);
            end_row       = CELL_W'(1);
            end_col       = CELL_W'(1);
            paths_checked = 0;
            mismatches    = 0;
        endfunction

        function void write_reg(gmbfs_pkg::t_cfg_idx idx, bit [CFG_DATA_W-1:0] data);
            case (idx)
                gmbfs_pkg::CFG_ROOMS_TALL: rooms_tall = data[DIM_W-1:0];
                gmbfs_pkg::CFG_ROOMS_WIDE: rooms_wide = data[DIM_W-1:0];
                gmbfs_pkg::CFG_START_ROW:  start_row  = data;
                gmbfs_pkg::CFG_START_COL:  start_col  = data;
                gmbfs_pkg::CFG_END_ROW:    end_row    = data;
                gmbfs_pkg::CFG_END_COL:    end_col    = data;
                default: ;
            endcase
        endfunction

        function bit is_open(int r, int c);
            return open_cells[r * CELL_COLS + c];
        endfunction

        function t_path_result shortest_room_path();
            t_path_result res;
            int t, w, sr, sc, r, c, dep, nr, nc, dr, dc, k;
            int q_row[$];
            int q_col[$];
            int q_dep[$];
            res = '0;
            t = (rooms_tall > MAX_T) ? MAX_T : rooms_tall;
            w = (rooms_wide > MAX_W) ? MAX_W : rooms_wide;
            seen_rooms = '0;
            if (!start_row[0] || !start_col[0])
                return res;
            sr = start_row >> 1;
            sc = start_col >> 1;
            if (sr >= t || sc >= w)
                return res;
            if (start_row == end_row && start_col == end_col) begin
                res.reached = 1'b1;
                return res;
            end
            seen_rooms[sr * w + sc] = 1'b1;
            q_row.push_back(sr);
            q_col.push_back(sc);
            q_dep.push_back(0);
            while (q_row.size() > 0) begin
                r   = q_row.pop_front();
                c   = q_col.pop_front();
                dep = q_dep.pop_front();
                for (k = 0; k < 4; k++) begin
                    case (gmbfs_pkg::t_dir'(k))
                        gmbfs_pkg::DIR_EAST:  begin dr = 0;  dc = 1;  end
                        gmbfs_pkg::DIR_SOUTH: begin dr = 1;  dc = 0;  end
                        gmbfs_pkg::DIR_WEST:  begin dr = 0;  dc = -1; end
                        default:              begin dr = -1; dc = 0;  end
                    endcase
                    nr = r + dr;
                    nc = c + dc;
                    if (nr < 0 || nc < 0 || nr >= t || nc >= w)
                        continue;
                    // The wall cell is looked at before the target room.
                    if (!is_open(2 * r + 1 + dr, 2 * c + 1 + dc))
                        continue;
                    if (!is_open(2 * nr + 1, 2 * nc + 1))
                        continue;
                    if (seen_rooms[nr * w + nc])
                        continue;
                    if (2 * nr + 1 == end_row && 2 * nc + 1 == end_col) begin
                        res.reached  = 1'b1;
                        res.distance = (dep + 1 > DIST_MAX) ? DIST_MAX : DIST_W'(dep + 1);
                        return res;
                    end
                    seen_rooms[nr * w + nc] = 1'b1;
                    q_row.push_back(nr);
                    q_col.push_back(nc);
                    q_dep.push_back(dep + 1);
                end
            end
            return res;
        endfunction

        function void note_beat(gmbfs_pkg::t_cmd cmd, bit [CELL_W-1:0] row,
                                bit [CELL_W-1:0] col, bit passable);
            if (cmd == gmbfs_pkg::CMD_LOAD) begin
                if (row < CELL_ROWS && col < CELL_COLS)
                    open_cells[row * CELL_COLS + col] = passable;
            end else begin
                awaited_paths.push_back(shortest_room_path());
            end
        endfunction

        function void check_path(logic [DIST_W-1:0] distance, logic reached);
            t_path_result want;
            paths_checked++;
            if (awaited_paths.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with none expected, actual distance %0d reached %0b",
                         $time, distance, reached);
                return;
            end
            want = awaited_paths.pop_front();
            if (distance !== want.distance) begin
                mismatches++;
                $display("%0t: distance expected %0d actual %0d",
                         $time, want.distance, distance);
            end
            if (reached !== want.reached) begin
                mismatches++;
                $display("%0t: reached expected %0b actual %0b",
                         $time, want.reached, reached);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    gmbfs_in_if  in_ch ();
    gmbfs_out_if out_ch ();
    gmbfs_cfg_if cfg_ch ();

    maze_path_board board;
    int             items_sent;
    int             tx_idle_pct;
    int             rx_stall_pct;
    bit             hold_off;
    bit             quiet_tail;

    grid_maze_bfs_shortest_path #(
        .MAX_ROOMS_TALL(MAX_T),
        .MAX_ROOMS_WIDE(MAX_W)
    ) uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    always #10 clk = ~clk;

    task automatic send_item(gmbfs_pkg::t_cmd cmd, bit [CELL_W-1:0] row,
                             bit [CELL_W-1:0] col, bit passable);
        int gap;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            gap = $urandom_range(1, 7);
            @(negedge clk);
            in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid    = 1'b1;
        in_ch.command  = cmd;
        in_ch.cell_row = row;
        in_ch.cell_col = col;
        in_ch.passable = passable;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        board.note_beat(cmd, row, col, passable);
    endtask

    task automatic load_cell(int row, int col, bit passable);
        send_item(gmbfs_pkg::CMD_LOAD, CELL_W'(row), CELL_W'(col), passable);
        if (row < CELL_ROWS && col < CELL_COLS)
            items_sent++;
    endtask

    task automatic run_search();
        // The unused fields of a search beat carry random bits.
        send_item(gmbfs_pkg::CMD_SEARCH, CELL_W'($urandom_range(0, 255)),
                  CELL_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        items_sent++;
    endtask

    // Waits until every search has reported and the block has gone quiet.
    task automatic settle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (board.awaited_paths.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(gmbfs_pkg::t_cfg_idx idx, bit [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_ends(bit [7:0] sr, bit [7:0] sc, bit [7:0] er, bit [7:0] ec);
        write_reg(gmbfs_pkg::CFG_START_ROW, sr);
        write_reg(gmbfs_pkg::CFG_START_COL, sc);
        write_reg(gmbfs_pkg::CFG_END_ROW, er);
        write_reg(gmbfs_pkg::CFG_END_COL, ec);
    endtask

    // Loads every cell of the configured maze, so that no search reads a
    // cell that was never written.
    task automatic fill_region(int wall_pct);
        int t, w, r, c;
        t = (board.rooms_tall > MAX_T) ? MAX_T : board.rooms_tall;
        w = (board.rooms_wide > MAX_W) ? MAX_W : board.rooms_wide;
        if (t == 0 || w == 0)
            return;
        for (r = 0; r <= 2 * t; r++) begin
            for (c = 0; c <= 2 * w; c++) begin
                if (r % 2 == 1 && c % 2 == 1)
                    load_cell(r, c, $urandom_range(0, 99) < 92);
                else
                    load_cell(r, c, $urandom_range(0, 99) < wall_pct);
            end
        end
    endtask

    task automatic pick_ends(int t, int w);
        int mode;
        bit [7:0] sr, sc, er, ec;
        mode = $urandom_range(0, 9);
        if (t == 0 || w == 0) begin
            sr = 8'($urandom_range(0, 255));
            sc = 8'($urandom_range(0, 255));
            er = 8'($urandom_range(0, 255));
            ec = 8'($urandom_range(0, 255));
        end else begin
            sr = 8'(2 * $urandom_range(0, t - 1) + 1);
            sc = 8'(2 * $urandom_range(0, w - 1) + 1);
            er = 8'(2 * $urandom_range(0, t - 1) + 1);
            ec = 8'(2 * $urandom_range(0, w - 1) + 1);
            if (mode == 7) begin
                er = sr;
                ec = sc;
            end else if (mode == 8) begin
                // Start off the room grid: an even coordinate or past the last room.
                case ($urandom_range(0, 3))
                    0: sr = 8'(2 * $urandom_range(0, t));
                    1: sc = 8'(2 * $urandom_range(0, w));
                    2: sr = 8'(2 * t + 1);
                    default: sc = 8'd255;
                endcase
            end else if (mode == 9) begin
                if ($urandom_range(0, 1))
                    er = 8'(2 * $urandom_range(0, t));
                else
                    ec = 8'(2 * w + 1);
            end
        end
        set_ends(sr, sc, er, ec);
    endtask

    task automatic toggle_cell(int t, int w);
        if (t > 0 && w > 0)
            load_cell($urandom_range(1, 2 * t - 1), $urandom_range(1, 2 * w - 1),
                      1'($urandom_range(0, 1)));
    endtask

    task automatic run_phase(bit [7:0] tall, bit [7:0] wide, int wall_pct, bit squeeze);
        int t, w, n, s;
        settle();
        if (!quiet_tail) begin
            tx_idle_pct  = $urandom_range(0, 1) ? 30 : 0;
            rx_stall_pct = $urandom_range(0, 1) ? 30 : 0;
        end
        if (squeeze)
            tx_idle_pct = 0;
        write_reg(gmbfs_pkg::CFG_ROOMS_TALL, tall);
        write_reg(gmbfs_pkg::CFG_ROOMS_WIDE, wide);
        t = (tall[6:0] > MAX_T) ? MAX_T : tall[6:0];
        w = (wide[6:0] > MAX_W) ? MAX_W : wide[6:0];
        fill_region(wall_pct);
        repeat ($urandom_range(0, 4))
            load_cell($urandom_range(0, 255), $urandom_range(0, 255),
                      1'($urandom_range(0, 1)));
        settle();
        pick_ends(t, w);
        n = squeeze ? 3 : $urandom_range(3, 6);
        // While the receiver holds off, searches pile up behind the output
        // register and the input stalls.
        if (squeeze)
            hold_off = 1'b1;
        for (s = 0; s < n; s++) begin
            if (!squeeze && s > 0 && $urandom_range(0, 1)) begin
                settle();
                pick_ends(t, w);
            end
            repeat ($urandom_range(0, 5)) toggle_cell(t, w);
            run_search();
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_path(out_ch.distance, out_ch.reached);
    end

    initial begin : result_sink
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_off = 1'b0;
            end else if ($urandom_range(0, 99) < rx_stall_pct) begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    initial begin : watchdog
        int idle_run;
        idle_run = 0;
        while (idle_run < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int p, k;
        bit [7:0] tall, wide;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.command  = gmbfs_pkg::CMD_LOAD;
        in_ch.cell_row = '0;
        in_ch.cell_col = '0;
        in_ch.passable = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = gmbfs_pkg::CFG_ROOMS_TALL;
        cfg_ch.data    = '0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        hold_off       = 1'b0;
        quiet_tail     = 1'b0;
        items_sent     = 0;
        board          = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Start and end are the same single room straight after reset.
        run_search();
        // The last cell of the store, then loads that fall outside it.
        load_cell(128, 128, 1'b1);
        load_cell(129, 0, 1'b1);
        load_cell(0, 129, 1'b0);
        load_cell(255, 255, 1'b1);
        settle();
        write_reg(gmbfs_pkg::CFG_ROOMS_WIDE, 8'd2);
        set_ends(8'd1, 8'd1, 8'd1, 8'd3);
        fill_region(50);
        load_cell(1, 2, 1'b0);
        load_cell(1, 3, 1'b1);
        run_search();
        load_cell(1, 2, 1'b1);
        run_search();
        settle();
        set_ends(8'd2, 8'd1, 8'd1, 8'd3);
        run_search();
        settle();
        set_ends(8'd1, 8'd1, 8'd2, 8'd3);
        run_search();
        settle();
        set_ends(8'd255, 8'd255, 8'd1, 8'd3);
        run_search();
        settle();
        set_ends(8'd1, 8'd3, 8'd1, 8'd3);
        run_search();
        settle();
        write_reg(gmbfs_pkg::CFG_ROOMS_TALL, 8'd0);
        set_ends(8'd1, 8'd1, 8'd1, 8'd3);
        run_search();

        // Long thin mazes at the size limits; 127 and 66 both act as 64.
        run_phase(8'h7F, 8'd1, 90, 1'b0);
        run_phase(8'd1, 8'hC2, 90, 1'b0);

        p = 0;
        while (items_sent < ITEM_GOAL || board.paths_checked < PATH_GOAL) begin
            if (items_sent >= ITEM_GOAL - 250) begin
                quiet_tail   = 1'b1;
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            k = $urandom_range(0, 9);
            if (k == 0) begin
                tall = 8'($urandom_range(9, 64));
                wide = 8'd1;
            end else if (k == 1) begin
                tall = 8'd1;
                wide = 8'($urandom_range(9, 40));
            end else begin
                tall = 8'($urandom_range(1, 6));
                wide = 8'($urandom_range(1, 6));
            end
            run_phase(tall, wide, $urandom_range(55, 80), p == 3);
            p++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
